// ===== src/rles_pkg.sv =====
package rles_pkg;

   // Kinds of request transaction.
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_EVENT = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CTRL_ACTION = 2'd0;
   localparam logic [1:0] CSR_CTRL_COLOR  = 2'd1;
   localparam logic [1:0] CSR_CTRL_CAP    = 2'd2;

   // Effect codes. Code 3 has no effect of its own and behaves as hold.
   localparam logic [1:0] ACT_HOLD    = 2'd0;
   localparam logic [1:0] ACT_BREATHE = 2'd1;
   localparam logic [1:0] ACT_STROBE  = 2'd2;

   // Color codes.
   localparam logic [2:0] COL_BLACK  = 3'd0;
   localparam logic [2:0] COL_RED    = 3'd1;
   localparam logic [2:0] COL_YELLOW = 3'd2;
   localparam logic [2:0] COL_GREEN  = 3'd3;
   localparam logic [2:0] COL_CYAN   = 3'd4;
   localparam logic [2:0] COL_BLUE   = 3'd5;
   localparam logic [2:0] COL_PURPLE = 3'd6;
   localparam logic [2:0] COL_WHITE  = 3'd7;

   localparam logic [6:0] CTRL_CAP_RESET = 7'd100;

   // The control event takes its entry from the configuration registers.
   localparam int CTRL_EVENT = 4;

   localparam int BREATHE_STEP_TICKS = 2;
   localparam int STROBE_DARK_TICKS  = 12;
   localparam int STROBE_LIT_TICKS   = 10;
   localparam int STROBE_TICK_W      = 4;

   typedef struct packed {
      logic active_now;
      logic active_next;
      logic go_dark;
   } evt_state_type;

   typedef struct packed {
      logic tick_go;
      logic go_dark;
   } eng_ctl_type;

   function automatic logic [1:0] fixed_action(input logic [3:0] idx);
      logic [1:0] act;
      case (idx)
         4'd1, 4'd5: act = ACT_BREATHE;
         default:    act = ACT_HOLD;
      endcase
      return act;
   endfunction

   function automatic logic [2:0] fixed_color(input logic [3:0] idx);
      logic [2:0] col;
      case (idx)
         4'd1, 4'd2: col = COL_GREEN;
         4'd3:       col = COL_RED;
         4'd4:       col = COL_WHITE;
         4'd5, 4'd6: col = COL_BLUE;
         default:    col = COL_BLACK;
      endcase
      return col;
   endfunction

   function automatic logic has_red(input logic [2:0] col);
      return (col == COL_RED) || (col == COL_YELLOW) || (col == COL_PURPLE) ||
             (col == COL_WHITE);
   endfunction

   function automatic logic has_green(input logic [2:0] col);
      return (col == COL_YELLOW) || (col == COL_GREEN) || (col == COL_CYAN) ||
             (col == COL_WHITE);
   endfunction

   function automatic logic has_blue(input logic [2:0] col);
      return (col == COL_CYAN) || (col == COL_BLUE) || (col == COL_PURPLE) ||
             (col == COL_WHITE);
   endfunction

endpackage

// ===== src/rles_req_if.sv =====
interface rles_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [2:0] event_id;
   logic       event_on;

   modport source(output valid, req_type, event_id, event_on, input ready);
   modport sink(input valid, req_type, event_id, event_on, output ready);
endinterface

// ===== src/rles_rsp_if.sv =====
interface rles_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] red_level;
   logic [6:0] green_level;
   logic [6:0] blue_level;
   logic [2:0] running_event;
   logic       lights_active;

   modport source(output valid, red_level, green_level, blue_level, running_event,
                  lights_active, input ready);
   modport sink(input valid, red_level, green_level, blue_level, running_event,
                lights_active, output ready);
endinterface

// ===== src/rles_csr_if.sv =====
interface rles_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] reg_index;
   logic [6:0] wdata;

   modport source(output valid, reg_index, wdata, input ready);
   modport sink(input valid, reg_index, wdata, output ready);
endinterface

// ===== src/rgb_led_effect_sequencer_top.sv =====
// Channel   Role     Payload
// req_chan  sink     req_type, event_id, event_on
// rsp_chan  source   red_level, green_level, blue_level, running_event, lights_active
// csr_chan  sink     reg_index, wdata (always ready)
//
// One request transaction yields one response transaction: an input register,
// then the event and effect logic into the response register. A new request
// can be taken every cycle while the response does not stall.
// A stalled response holds the input register; ready drops only when both
// registers are full. Synchronous reset clears the event and effect state.
module rgb_led_effect_sequencer_top
   import rles_pkg::*;
#(
   parameter int NUM_EVENTS         = 7,
   parameter int LEVEL_MAX          = 100,
   parameter int BREATHE_MIN        = 4,
   parameter int BREATHE_DARK_TICKS = 50
) (
   input logic        clock,
   input logic        reset,
   rles_req_if.sink   req_chan,
   rles_rsp_if.source rsp_chan,
   rles_csr_if.sink   csr_chan
);

   localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
   localparam int LW = $clog2(LEVEL_MAX + 1);

   logic          in_valid_ff;
   logic          in_type_ff;
   logic [2:0]    in_id_ff;
   logic          in_on_ff;

   logic          rsp_valid_ff;
   logic [6:0]    red_ff, green_ff, blue_ff;
   logic [2:0]    running_ff;
   logic          lights_ff;

   logic [1:0]    ctrl_action_ff;
   logic [2:0]    ctrl_color_ff;
   logic [6:0]    ctrl_cap_ff;

   logic          advance;
   logic          req_take;
   evt_state_type evt;
   eng_ctl_type   ctl;
   logic [EW-1:0] current_now;
   logic [EW-1:0] current_next;
   logic [LW-1:0] red_in, green_in, blue_in;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign ctl.tick_go = advance && (in_type_ff == REQ_TICK) && evt.active_now;
   assign ctl.go_dark = evt.go_dark;

   rles_event_ctrl #(
      .NUM_EVENTS(NUM_EVENTS)
   ) u_event_ctrl (
      .clock        (clock),
      .reset        (reset),
      .event_go     (advance && (in_type_ff == REQ_EVENT)),
      .event_id     (in_id_ff),
      .event_on     (in_on_ff),
      .evt          (evt),
      .current_now  (current_now),
      .current_next (current_next)
   );

   rles_effect_engine #(
      .NUM_EVENTS         (NUM_EVENTS),
      .LEVEL_MAX          (LEVEL_MAX),
      .BREATHE_MIN        (BREATHE_MIN),
      .BREATHE_DARK_TICKS (BREATHE_DARK_TICKS)
   ) u_effect_engine (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .current_event  (current_now),
      .ctrl_action    (ctrl_action_ff),
      .ctrl_color     (ctrl_color_ff),
      .ctrl_level_cap (ctrl_cap_ff),
      .red_in         (red_in),
      .green_in       (green_in),
      .blue_in        (blue_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (req_take) begin
         in_type_ff <= req_chan.req_type;
         in_id_ff   <= req_chan.event_id;
         in_on_ff   <= req_chan.event_on;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         red_ff     <= 7'(red_in);
         green_ff   <= 7'(green_in);
         blue_ff    <= 7'(blue_in);
         running_ff <= evt.active_next ? 3'(current_next) : 3'd0;
         lights_ff  <= evt.active_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_action_ff <= ACT_HOLD;
         ctrl_color_ff  <= COL_WHITE;
         ctrl_cap_ff    <= CTRL_CAP_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.reg_index)
            CSR_CTRL_ACTION: ctrl_action_ff <= csr_chan.wdata[1:0];
            CSR_CTRL_COLOR:  ctrl_color_ff  <= csr_chan.wdata[2:0];
            CSR_CTRL_CAP:    ctrl_cap_ff    <= csr_chan.wdata;
            default:         ctrl_cap_ff    <= ctrl_cap_ff;
         endcase
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.red_level     = red_ff;
   assign rsp_chan.green_level   = green_ff;
   assign rsp_chan.blue_level    = blue_ff;
   assign rsp_chan.running_event = running_ff;
   assign rsp_chan.lights_active = lights_ff;

   // An idle block always shows dark levels and event zero.
   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !lights_ff |->
         red_ff == 7'd0 && green_ff == 7'd0 && blue_ff == 7'd0 && running_ff == 3'd0)
      else $error("idle response carries light");

   // Withdrawing the last event darkens the next response.
   a_go_dark: assert property (@(posedge clock) disable iff (reset)
      ctl.go_dark |=> rsp_valid_ff && !lights_ff && red_ff == 7'd0)
      else $error("last event withdrawn but response not dark");

   // A tick only advances effects while an event is raised.
   a_tick_active: assert property (@(posedge clock) disable iff (reset)
      ctl.tick_go |-> evt.active_now && evt.active_next && !ctl.go_dark)
      else $error("effect tick while idle");

   // A waiting request is neither lost nor altered while the response stalls.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=>
         in_valid_ff && $stable(in_type_ff) && $stable(in_id_ff) && $stable(in_on_ff))
      else $error("stalled request changed");

endmodule

// ===== src/rles_event_ctrl.sv =====
module rles_event_ctrl
   import rles_pkg::*;
#(
   parameter int NUM_EVENTS = 7,
   localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          event_go,
   input  logic [2:0]    event_id,
   input  logic          event_on,
   output evt_state_type evt,
   output logic [EW-1:0] current_now,
   output logic [EW-1:0] current_next
);

   localparam int IDW_RAW = $clog2(NUM_EVENTS + 1);
   localparam int IDW     = (IDW_RAW > 3) ? IDW_RAW : 3;

   logic [NUM_EVENTS-1:0] requests_ff;
   logic [NUM_EVENTS-1:0] requests_in;
   logic                  active_ff;
   logic                  active_in;
   logic [EW-1:0]         current_ff;
   logic [EW-1:0]         current_in;
   logic [EW-1:0]         lowest;
   logic [IDW-1:0]        id_wide;
   logic                  in_range;
   logic                  take;

   assign id_wide  = IDW'(event_id);
   assign in_range = id_wide < IDW'(NUM_EVENTS);
   assign take     = event_go && in_range;

   always_comb begin
      requests_in = requests_ff;
      for (int i = 0; i < NUM_EVENTS; i++) begin
         if (id_wide == IDW'(i)) begin
            requests_in[i] = event_on;
         end
      end
   end

   // Priority encoder: the lowest raised request wins.
   always_comb begin
      lowest = '0;
      for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
         if (requests_in[i]) begin
            lowest = EW'(i);
         end
      end
   end

   always_comb begin
      active_in  = active_ff;
      current_in = current_ff;
      if (take) begin
         active_in = |requests_in;
         if (|requests_in) begin
            current_in = lowest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         requests_ff <= '0;
         active_ff   <= 1'b0;
         current_ff  <= '0;
      end else if (take) begin
         requests_ff <= requests_in;
         active_ff   <= active_in;
         current_ff  <= current_in;
      end
   end

   assign evt.active_now  = active_ff;
   assign evt.active_next = active_in;
   assign evt.go_dark     = take && active_ff && !(|requests_in);
   assign current_now     = current_ff;
   assign current_next    = current_in;

endmodule

// ===== src/rles_effect_engine.sv =====
module rles_effect_engine
   import rles_pkg::*;
#(
   parameter int NUM_EVENTS         = 7,
   parameter int LEVEL_MAX          = 100,
   parameter int BREATHE_MIN        = 4,
   parameter int BREATHE_DARK_TICKS = 50,
   localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1,
   localparam int LW = $clog2(LEVEL_MAX + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  eng_ctl_type   ctl,
   input  logic [EW-1:0] current_event,
   input  logic [1:0]    ctrl_action,
   input  logic [2:0]    ctrl_color,
   input  logic [6:0]    ctrl_level_cap,
   output logic [LW-1:0] red_in,
   output logic [LW-1:0] green_in,
   output logic [LW-1:0] blue_in
);

   localparam int BMAX    = (LEVEL_MAX > BREATHE_MIN) ? LEVEL_MAX : BREATHE_MIN;
   localparam int BLW     = $clog2(BMAX + 1);
   localparam int BTW_RAW = $clog2(BREATHE_DARK_TICKS + 1);
   localparam int BTW     = (BTW_RAW > 2) ? BTW_RAW : 2;
   localparam int CMW     = (LW > 7) ? LW : 7;
   localparam int STW     = STROBE_TICK_W;

   typedef enum logic [1:0] {
      BR_DARK,
      BR_RISE,
      BR_FALL
   } breathe_phase_type;

   typedef enum logic [1:0] {
      ST_DARK,
      ST_LIT,
      ST_GAP
   } strobe_phase_type;

   breathe_phase_type b_phase_ff, b_phase_in;
   logic [BTW-1:0]    b_ticks_ff, b_ticks_in;
   logic [BLW-1:0]    b_level_ff, b_level_in;
   logic [BTW:0]      b_step;
   logic [BLW:0]      b_lv;

   strobe_phase_type  s_phase_ff, s_phase_in;
   logic [STW-1:0]    s_ticks_ff, s_ticks_in;
   logic [LW-1:0]     s_level;

   logic [LW-1:0]     entry_ff [NUM_EVENTS];
   logic [LW-1:0]     held_ff  [3];

   logic              is_ctrl;
   logic [1:0]        act;
   logic [2:0]        col;
   logic [CMW-1:0]    cap_wide;
   logic [LW-1:0]     cap;
   logic [LW-1:0]     cur_level;
   logic [BLW-1:0]    raw_level;
   logic [LW-1:0]     new_level;
   logic              breathe_go;
   logic              strobe_go;

   assign is_ctrl = int'(current_event) == CTRL_EVENT;
   assign act     = is_ctrl ? ctrl_action : fixed_action(4'(current_event));
   assign col     = is_ctrl ? ctrl_color  : fixed_color(4'(current_event));

   assign cap_wide = CMW'(ctrl_level_cap);
   assign cap = !is_ctrl ? LW'(LEVEL_MAX) :
                (cap_wide > CMW'(LEVEL_MAX)) ? LW'(LEVEL_MAX) : LW'(cap_wide);

   assign breathe_go = ctl.tick_go && (act == ACT_BREATHE);
   assign strobe_go  = ctl.tick_go && (act == ACT_STROBE);
   assign cur_level  = entry_ff[current_event];

   // Breathe: dark hold at the floor, then one step up or down every
   // second tick between the floor and the full level.
   always_comb begin
      b_phase_in = b_phase_ff;
      b_ticks_in = b_ticks_ff;
      b_level_in = b_level_ff;
      b_step     = {1'b0, b_ticks_ff} + 1'b1;
      b_lv       = {1'b0, b_level_ff};
      unique case (b_phase_ff)
         BR_DARK: begin
            if (b_ticks_ff >= BTW'(BREATHE_DARK_TICKS)) begin
               b_phase_in = BR_RISE;
               b_ticks_in = BTW'(1);
            end else begin
               b_ticks_in = BTW'(b_step);
            end
            b_level_in = BLW'(BREATHE_MIN);
         end
         BR_RISE: begin
            if (b_step >= (BTW+1)'(BREATHE_STEP_TICKS)) begin
               b_lv   = b_lv + 1'b1;
               b_step = '0;
            end
            if (b_lv >= (BLW+1)'(LEVEL_MAX)) begin
               b_lv       = (BLW+1)'(LEVEL_MAX);
               b_phase_in = BR_FALL;
               b_step     = '0;
            end
            b_ticks_in = BTW'(b_step);
            b_level_in = BLW'(b_lv);
         end
         BR_FALL: begin
            if (b_step >= (BTW+1)'(BREATHE_STEP_TICKS)) begin
               if (b_lv != '0) begin
                  b_lv = b_lv - 1'b1;
               end
               b_step = '0;
            end
            if (b_lv <= (BLW+1)'(BREATHE_MIN)) begin
               b_lv       = (BLW+1)'(BREATHE_MIN);
               b_phase_in = BR_DARK;
               b_step     = '0;
            end
            b_ticks_in = BTW'(b_step);
            b_level_in = BLW'(b_lv);
         end
         default: begin
            b_phase_in = b_phase_ff;
         end
      endcase
   end

   always_comb begin
      s_phase_in = s_phase_ff;
      s_ticks_in = s_ticks_ff + 1'b1;
      s_level    = cur_level;
      unique case (s_phase_ff)
         ST_DARK: begin
            s_level = '0;
            if (s_ticks_ff >= STW'(STROBE_DARK_TICKS)) begin
               s_phase_in = ST_LIT;
               s_ticks_in = STW'(1);
            end
         end
         ST_LIT: begin
            s_level = LW'(LEVEL_MAX);
            if (s_ticks_ff >= STW'(STROBE_LIT_TICKS)) begin
               s_phase_in = ST_GAP;
               s_ticks_in = STW'(1);
            end
         end
         ST_GAP: begin
            s_level = '0;
            if (s_ticks_ff > STW'(STROBE_DARK_TICKS)) begin
               s_phase_in = ST_DARK;
               s_ticks_in = STW'(1);
            end
         end
         default: begin
            s_ticks_in = s_ticks_ff;
         end
      endcase
   end

   always_comb begin
      if (act == ACT_BREATHE) begin
         raw_level = b_level_in;
      end else if (act == ACT_STROBE) begin
         raw_level = BLW'(s_level);
      end else begin
         raw_level = BLW'(cur_level);
      end
      new_level = (raw_level > BLW'(cap)) ? cap : LW'(raw_level);
   end

   always_comb begin
      red_in   = held_ff[0];
      green_in = held_ff[1];
      blue_in  = held_ff[2];
      if (ctl.tick_go) begin
         red_in   = has_red(col)   ? new_level : '0;
         green_in = has_green(col) ? new_level : '0;
         blue_in  = has_blue(col)  ? new_level : '0;
      end else if (ctl.go_dark) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_phase_ff <= BR_DARK;
         b_ticks_ff <= '0;
         b_level_ff <= BLW'(BREATHE_MIN);
         s_phase_ff <= ST_DARK;
         s_ticks_ff <= '0;
         held_ff[0] <= '0;
         held_ff[1] <= '0;
         held_ff[2] <= '0;
         for (int i = 0; i < NUM_EVENTS; i++) begin
            entry_ff[i] <= (i == 0) ? '0 : LW'(LEVEL_MAX);
         end
      end else begin
         if (breathe_go) begin
            b_phase_ff <= b_phase_in;
            b_ticks_ff <= b_ticks_in;
            b_level_ff <= b_level_in;
         end
         if (strobe_go) begin
            s_phase_ff <= s_phase_in;
            s_ticks_ff <= s_ticks_in;
         end
         if (ctl.tick_go) begin
            entry_ff[current_event] <= new_level;
         end
         held_ff[0] <= red_in;
         held_ff[1] <= green_in;
         held_ff[2] <= blue_in;
      end
   end

endmodule
